// ===== sv/sfs_pkg.sv =====
// ----------------------------------------------------------------------------
// sfs_pkg: shared types and constants for the full-step stepper sequencer
// Holds the command and status codes, register map, limits and phase table.
// ----------------------------------------------------------------------------
`default_nettype none

package sfs_pkg;

	localparam int unsigned CountW  = 14;
	localparam int unsigned DelayW  = 14;
	localparam int unsigned PctW    = 6;
	localparam int unsigned PwmW    = 8;
	localparam int unsigned AddrW   = 3;
	localparam int unsigned DataW   = 32;

	localparam logic [CountW-1:0] MaxSteps   = 14'd10000;
	localparam logic [DelayW-1:0] DelayMin   = 14'd500;
	localparam logic [DelayW-1:0] DelayMax   = 14'd10000;
	localparam logic [DelayW-1:0] DelayReset = 14'd2000;
	localparam logic [PctW-1:0]   PctMin     = 6'd10;
	localparam logic [PctW-1:0]   PctMax     = 6'd60;
	localparam logic [PctW-1:0]   PctReset   = 6'd40;
	// level for the reset percentage: 40*255/100
	localparam logic [PwmW-1:0]   PwmReset   = 8'd102;
	// 5243 / 2^19 approximates 1/100 closely enough for values below 2^14
	localparam logic [12:0]       RecipHundred = 13'd5243;
	localparam int unsigned       RecipShift   = 19;

	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_ENABLE  = 2'd1,
		OP_DISABLE = 2'd2,
		OP_MOVE    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_RANGE     = 2'd1,
		ST_DRIVE_OFF = 2'd2,
		ST_BUSY      = 2'd3
	} status_t;

	typedef enum logic {
		REG_STEP_DELAY    = 1'b0,
		REG_DRIVE_PERCENT = 1'b1
	} reg_idx_t;

	// bridge inputs per phase: bit3 A+, bit2 A-, bit1 B+, bit0 B-
	function automatic logic [3:0] coil_pattern(input logic [1:0] phase);
		logic [3:0] pat;
		case (phase)
			2'd0:    pat = 4'hA;
			2'd1:    pat = 4'h6;
			2'd2:    pat = 4'h5;
			2'd3:    pat = 4'h9;
			default: pat = 4'h0;
		endcase
		return pat;
	endfunction

endpackage

`default_nettype wire

// ===== sv/sfs_if.sv =====
// ----------------------------------------------------------------------------
// sfs_if: request channels of the full-step stepper sequencer
// Command channel into the block and result channel out of it.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfs_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic        forward;
	logic [13:0] step_count;

	modport source (output valid, op, forward, step_count, input ready);
	modport sink   (input valid, op, forward, step_count, output ready);
endinterface

interface sfs_res_if;
	logic       valid;
	logic       ready;
	logic [3:0] coil_drive;
	logic [7:0] pwm_level;
	logic       driver_on;
	logic       busy_res;
	logic [1:0] phase_now;
	logic [1:0] status;

	modport source (output valid, coil_drive, pwm_level, driver_on, busy_res, phase_now,
		status, input ready);
	modport sink   (input valid, coil_drive, pwm_level, driver_on, busy_res, phase_now,
		status, output ready);
endinterface

`default_nettype wire

// ===== sv/stepper_full_step_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// stepper_full_step_sequencer_unit: four-phase full-step stepper sequencer
// Turns tick, enable, disable and move requests into bridge and PWM levels.
// ----------------------------------------------------------------------------
// Usage:
//   cmd  : one request per handshake (op, forward, step_count). A tick request
//          stands for one microsecond; moves run on these ticks.
//   res  : exactly one result per request, in order: coil pattern, PWM level,
//          driver state, busy flag, phase and move status.
//   APB  : step_delay_us at 0x0, drive_percent at 0x4; writes outside the
//          legal range are dropped. Write only while no request is in flight.
// A request is registered in the input stage, then in the result register that
// holds the state update. One request is taken every cycle as long as the
// result register empties; the input stage and the result register form a
// two-deep queue, so a stalled receiver backs up into cmd.ready only once both
// are full.
// Reset leaves the driver off, phase 0, no move running, delay 2000 ticks and
// drive 40 percent. A disable aborts any running move.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_full_step_sequencer_unit
	import sfs_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	sfs_cmd_if.sink               cmd,
	sfs_res_if.source             res,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [AddrW-1:0] paddr,
	input  wire logic [DataW-1:0] pwdata,
	output logic      [DataW-1:0] prdata,
	output logic                  pready
);

	// configuration
	logic [DelayW-1:0] step_delay_q;
	logic [PctW-1:0]   drive_pct_q;
	logic [PwmW-1:0]   pwm_lvl_q;

	// sequencer state
	logic              enabled_q;
	logic [1:0]        phase_q;
	logic [CountW-1:0] steps_left_q;
	logic [DelayW-1:0] delay_left_q;
	logic              dir_q;

	// input stage
	logic              valid_s1;
	op_t               op_s1;
	logic              fwd_s1;
	logic [CountW-1:0] count_s1;

	// result stage
	logic              valid_s2;
	logic [3:0]        coil_s2;
	logic [PwmW-1:0]   pwm_s2;
	logic              on_s2;
	logic              busy_s2;
	logic [1:0]        phase_s2;
	status_t           status_s2;

	logic              advance;
	logic              wr_en;
	reg_idx_t          wr_idx;
	logic [DelayW-1:0] wr_delay;
	logic [PctW-1:0]   wr_pct;
	logic [13:0]       pct_x255;
	logic [26:0]       pwm_prod;

	logic              enabled_d;
	logic [1:0]        phase_d;
	logic [CountW-1:0] steps_left_d;
	logic [DelayW-1:0] delay_left_d;
	logic              dir_d;
	status_t           status_d;
	logic [DelayW-1:0] delay_dec;
	logic [1:0]        phase_step;

	// ------------------------------------------------------------------ APB
	assign pready   = 1'b1;
	assign wr_en    = psel && penable && pwrite;
	assign wr_idx   = reg_idx_t'(paddr[2]);
	assign wr_delay = pwdata[DelayW-1:0];
	assign wr_pct   = pwdata[PctW-1:0];
	assign pct_x255 = {wr_pct, 8'b0} - {8'b0, wr_pct};
	assign pwm_prod = pct_x255 * RecipHundred;

	always_comb begin
		case (wr_idx)
			REG_STEP_DELAY:    prdata = {{(DataW-DelayW){1'b0}}, step_delay_q};
			REG_DRIVE_PERCENT: prdata = {{(DataW-PctW){1'b0}}, drive_pct_q};
			default:           prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_delay_q <= DelayReset;
			drive_pct_q  <= PctReset;
			pwm_lvl_q    <= PwmReset;
		end else if (wr_en) begin
			case (wr_idx)
				REG_STEP_DELAY: begin
					if (wr_delay >= DelayMin && wr_delay <= DelayMax) begin
						step_delay_q <= wr_delay;
					end
				end
				REG_DRIVE_PERCENT: begin
					if (wr_pct >= PctMin && wr_pct <= PctMax) begin
						drive_pct_q <= wr_pct;
						pwm_lvl_q   <= pwm_prod[RecipShift +: PwmW];
					end
				end
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------ handshake
	assign advance   = valid_s1 && (!valid_s2 || res.ready);
	assign cmd.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			op_s1    <= op_t'(cmd.op);
			fwd_s1   <= cmd.forward;
			count_s1 <= cmd.step_count;
		end
	end

	// ------------------------------------------------------- state update
	assign delay_dec  = delay_left_q - 1'b1;

	always_comb begin
		enabled_d    = enabled_q;
		phase_d      = phase_q;
		steps_left_d = steps_left_q;
		delay_left_d = delay_left_q;
		dir_d        = dir_q;
		status_d     = ST_OK;
		phase_step   = dir_q ? 2'd1 : 2'd3;
		case (op_s1)
			OP_TICK: begin
				if (delay_left_q != '0) begin
					delay_left_d = delay_dec;
					// delay ran out with steps pending: take the next step, reload
					if (delay_dec == '0 && steps_left_q != '0) begin
						phase_d      = phase_q + phase_step;
						steps_left_d = steps_left_q - 1'b1;
						delay_left_d = step_delay_q;
					end
				end
			end
			OP_ENABLE: begin
				enabled_d = 1'b1;
			end
			OP_DISABLE: begin
				enabled_d    = 1'b0;
				steps_left_d = '0;
				delay_left_d = '0;
			end
			OP_MOVE: begin
				if (count_s1 == '0 || count_s1 > MaxSteps) begin
					status_d = ST_RANGE;
				end else if (!enabled_q) begin
					status_d = ST_DRIVE_OFF;
				end else if (delay_left_q != '0) begin
					status_d = ST_BUSY;
				end else begin
					dir_d        = fwd_s1;
					phase_d      = phase_q + (fwd_s1 ? 2'd1 : 2'd3);
					steps_left_d = count_s1 - 1'b1;
					delay_left_d = step_delay_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q    <= 1'b0;
			phase_q      <= 2'd0;
			steps_left_q <= '0;
			delay_left_q <= '0;
			dir_q        <= 1'b0;
		end else if (advance) begin
			enabled_q    <= enabled_d;
			phase_q      <= phase_d;
			steps_left_q <= steps_left_d;
			delay_left_q <= delay_left_d;
			dir_q        <= dir_d;
		end
	end

	// ------------------------------------------------------- result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			coil_s2   <= enabled_d ? coil_pattern(phase_d) : 4'h0;
			pwm_s2    <= enabled_d ? pwm_lvl_q : '0;
			on_s2     <= enabled_d;
			busy_s2   <= (delay_left_d != '0);
			phase_s2  <= phase_d;
			status_s2 <= status_d;
		end
	end

	assign res.valid      = valid_s2;
	assign res.coil_drive = coil_s2;
	assign res.pwm_level  = pwm_s2;
	assign res.driver_on  = on_s2;
	assign res.busy_res   = busy_s2;
	assign res.phase_now  = phase_s2;
	assign res.status     = status_s2;

	// ------------------------------------------------------------ assertions
	a_steps_need_delay: assert property (@(posedge clk) disable iff (!arst_n)
		steps_left_q != '0 |-> delay_left_q != '0)
		else $error("steps pending with no delay running");

	a_off_is_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!enabled_q |-> (delay_left_q == '0 && steps_left_q == '0))
		else $error("move state left over while driver off");

	a_delay_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_delay_q >= DelayMin && step_delay_q <= DelayMax)
		else $error("step delay register out of range");

	a_off_outputs_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !on_s2) |-> (coil_s2 == 4'h0 && pwm_s2 == '0))
		else $error("bridge driven while driver off");

	a_reject_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && status_d != ST_OK) |=>
			($stable(phase_q) && $stable(delay_left_q) && $stable(steps_left_q)))
		else $error("rejected move changed sequencer state");

endmodule

`default_nettype wire
